FILE: rtl/border_label_clear_unit_defines.svh
// ---------------------------------------------------------------------------
// border label clear unit: assertion macros
// shared assertion wrappers for the border label clear unit
// ---------------------------------------------------------------------------
`ifndef BORDER_LABEL_CLEAR_UNIT_DEFINES_SVH
`define BORDER_LABEL_CLEAR_UNIT_DEFINES_SVH

// check sampled on the rising edge, switched off while reset is held
`define BCL_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on every rising edge, reset included
`define BCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bcl_pkg.sv
// ---------------------------------------------------------------------------
// bcl_pkg
// types and constants shared by the border label clear unit and its cells
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcl_pkg;

    // number of cells in the search chain and the bits that pick one
    localparam int N_CELLS   = 8;
    localparam int CELL_BITS = 3;

    // request opcodes; the remaining code is ignored
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SCAN   = 2'd1,
        OP_FILTER = 2'd2
    } t_opcode;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SIZE_X    = 2'd0,
        CFG_SIZE_Y    = 2'd1,
        CFG_SIZE_Z    = 2'd2,
        CFG_SEEDS_ENA = 2'd3
    } t_cfg_idx;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic                 clear_hit;
        logic                 rd_valid;
        logic                 row_full;
        logic                 row_part;
        logic [CELL_BITS-1:0] cnt_low;
    } t_cell_ctrl;

endpackage

FILE: rtl/bcl_ram.sv
// ---------------------------------------------------------------------------
// bcl_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/bcl_cell.sv
// ---------------------------------------------------------------------------
// bcl_cell
// one search cell: a slice of the label set and a sticky hit handed down
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcl_cell #(
    parameter int LABEL_BITS = 16,
    parameter int ROWS       = 256,
    parameter int CELL_ID    = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bcl_pkg::t_cell_ctrl     i_ctrl,
    input  logic                    i_we,
    input  logic [$clog2(ROWS)-1:0] i_wrow,
    input  logic [LABEL_BITS-1:0]   i_wdata,
    input  logic [$clog2(ROWS)-1:0] i_rrow,
    input  logic [LABEL_BITS-1:0]   i_probe,
    input  logic                    i_hit,
    output logic                    o_hit
);

    localparam logic [bcl_pkg::CELL_BITS-1:0] ID = bcl_pkg::CELL_BITS'(CELL_ID);

    logic [LABEL_BITS-1:0] w_rdata;
    logic                  w_in_use;
    logic                  w_match;
    logic                  r_hit;

    // slice of the set: entry row*N_CELLS+CELL_ID lives at row
    bcl_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_wrow),
        .i_wdata (i_wdata),
        .i_raddr (i_rrow),
        .o_rdata (w_rdata)
    );

    // entry is held only if its index is below the fill count
    assign w_in_use = i_ctrl.row_full || (i_ctrl.row_part && (ID < i_ctrl.cnt_low));
    assign w_match  = i_ctrl.rd_valid && w_in_use && (w_rdata == i_probe);

    // sticky hit, merged with the neighbour's and passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear_hit) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= r_hit | i_hit | w_match;
        end
    end

    assign o_hit = r_hit;

endmodule

FILE: rtl/border_label_clear_unit.sv
// ---------------------------------------------------------------------------
// border_label_clear_unit
// keeps the set of labels touching the volume faces and filters voxels by it
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result follows
// on o_valid for a single cycle and cannot be held off. Clear, the unused
// opcode and a scan voxel that is not on a face of the volume give their
// result in the next cycle with busy staying low. A filter voxel, or a scan
// voxel on a face, searches the set: the eight-cell chain reads one row of
// eight entries per cycle, then the hit drains down the chain and a decision
// step gives the result (an empty set skips sweep and drain). The set needs no
// clearing pass after reset; the fill count alone marks valid entries. The user
// writes configuration only while busy is low; the block does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "border_label_clear_unit_defines.svh"

module border_label_clear_unit #(
    parameter int LABEL_BITS = 16,
    parameter int SET_DEPTH  = 2048,
    parameter int COORD_BITS = 12,
    localparam int CNT_BITS  = $clog2(SET_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_opcode,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [COORD_BITS-1:0] i_pos_z,
    input  logic [LABEL_BITS-1:0] i_label_in,
    input  logic [LABEL_BITS-1:0] i_seed_in,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [COORD_BITS:0]   i_cfg_data,
    // result
    output logic                  o_valid,
    output logic [LABEL_BITS-1:0] o_label_out,
    output logic [LABEL_BITS-1:0] o_seed_out,
    output logic                  o_removed,
    output logic [CNT_BITS-1:0]   o_labels_found,
    output logic                  o_set_full
);

    localparam int NC       = bcl_pkg::N_CELLS;
    localparam int CB       = bcl_pkg::CELL_BITS;
    localparam int ROWS     = (SET_DEPTH + NC - 1) / NC;
    localparam int ROW_BITS = $clog2(ROWS);
    localparam int SZ_BITS  = COORD_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    t_state                r_state;
    bcl_pkg::t_opcode      r_op;
    logic [LABEL_BITS-1:0] r_label;
    logic [LABEL_BITS-1:0] r_seed;
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_flag;
    logic [ROW_BITS-1:0]   r_row;
    logic [ROW_BITS-1:0]   r_rd_row;
    logic                  r_rd_valid;
    logic [CB:0]           r_drain;
    logic [SZ_BITS-1:0]    r_size_x;
    logic [SZ_BITS-1:0]    r_size_y;
    logic [SZ_BITS-1:0]    r_size_z;
    logic                  r_seeds_en;
    logic                  r_valid;
    logic [LABEL_BITS-1:0] r_label_out;
    logic [LABEL_BITS-1:0] r_seed_out;
    logic                  r_removed;
    logic [CNT_BITS-1:0]   r_cnt_out;
    logic                  r_full_out;

    logic                  w_accept;
    logic                  w_border;
    logic                  w_hit_final;
    logic                  w_we;
    logic [CNT_BITS-1:0]   w_last_row;
    logic [CNT_BITS-1:0]   n_count;
    logic [ROW_BITS-1:0]   w_wrow;
    bcl_pkg::t_cell_ctrl   w_ctrl;
    logic [NC-1:0]         w_hit;
    logic [NC-1:0]         w_hit_in;

    // true when a coordinate lies on either face of its axis
    function automatic logic on_face(input logic [COORD_BITS-1:0] p,
                                     input logic [SZ_BITS-1:0] size);
        logic [SZ_BITS-1:0] p_ext;
        p_ext   = {1'b0, p};
        on_face = (p == '0) || (SZ_BITS'(p_ext + 1'b1) == size);
    endfunction

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // voxel inside the volume and on one of its faces
    assign w_border = ({1'b0, i_pos_x} < r_size_x) && ({1'b0, i_pos_y} < r_size_y) &&
                      ({1'b0, i_pos_z} < r_size_z) &&
                      (on_face(i_pos_x, r_size_x) || on_face(i_pos_y, r_size_y) ||
                       on_face(i_pos_z, r_size_z));

    // sweep bounds and row occupancy from the fill count
    assign w_last_row = CNT_BITS'(r_count - 1'b1) >> CB;
    assign w_ctrl.clear_hit = w_accept;
    assign w_ctrl.rd_valid  = r_rd_valid;
    assign w_ctrl.row_full  = CNT_BITS'(r_rd_row) < (r_count >> CB);
    assign w_ctrl.row_part  = CNT_BITS'(r_rd_row) == (r_count >> CB);
    assign w_ctrl.cnt_low   = r_count[CB-1:0];

    // insertion of a new border label at the fill count
    assign w_hit_final = w_hit[NC-1];
    assign w_we   = (r_state == ST_DECIDE) && (r_op == bcl_pkg::OP_SCAN) && !w_hit_final &&
                    (r_count < CNT_BITS'(SET_DEPTH));
    assign w_wrow = ROW_BITS'(r_count >> CB);
    assign n_count = CNT_BITS'(r_count + 1'b1);

    // chain of search cells
    for (genvar c = 0; c < NC; c++) begin : g_cell
        if (c == 0) begin : g_head
            assign w_hit_in[c] = 1'b0;
        end else begin : g_link
            assign w_hit_in[c] = w_hit[c-1];
        end

        bcl_cell #(
            .LABEL_BITS (LABEL_BITS),
            .ROWS       (ROWS),
            .CELL_ID    (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_we    (w_we && (r_count[CB-1:0] == CB'(c))),
            .i_wrow  (w_wrow),
            .i_wdata (r_label),
            .i_rrow  (r_row),
            .i_probe (r_label),
            .i_hit   (w_hit_in[c]),
            .o_hit   (w_hit[c])
        );
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x   <= SZ_BITS'(1);
            r_size_y   <= SZ_BITS'(1);
            r_size_z   <= SZ_BITS'(1);
            r_seeds_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (bcl_pkg::t_cfg_idx'(i_cfg_addr))
                bcl_pkg::CFG_SIZE_X:    r_size_x   <= i_cfg_data;
                bcl_pkg::CFG_SIZE_Y:    r_size_y   <= i_cfg_data;
                bcl_pkg::CFG_SIZE_Z:    r_size_z   <= i_cfg_data;
                bcl_pkg::CFG_SEEDS_ENA: r_seeds_en <= i_cfg_data[0];
            endcase
        end
    end

    // read pipeline tag: row whose data leaves the rams this cycle
    always_ff @(posedge i_clk) begin
        r_rd_row <= r_row;
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= (r_state == ST_SWEEP);
        end
    end

    // sequencer, set state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_flag  <= 1'b0;
            r_valid <= 1'b0;
            r_row   <= '0;
            r_drain <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op        <= bcl_pkg::t_opcode'(i_opcode);
                        r_label     <= i_label_in;
                        r_seed      <= i_seed_in;
                        r_row       <= '0;
                        r_label_out <= '0;
                        r_seed_out  <= '0;
                        r_removed   <= 1'b0;
                        r_cnt_out   <= r_count;
                        r_full_out  <= r_flag;
                        unique case (bcl_pkg::t_opcode'(i_opcode))
                            bcl_pkg::OP_CLEAR: begin
                                r_count    <= '0;
                                r_flag     <= 1'b0;
                                r_cnt_out  <= '0;
                                r_full_out <= 1'b0;
                                r_valid    <= 1'b1;
                            end
                            bcl_pkg::OP_SCAN: begin
                                if (!w_border) begin
                                    r_valid <= 1'b1;
                                end else if (r_count == '0) begin
                                    r_state <= ST_DECIDE;
                                end else begin
                                    r_state <= ST_SWEEP;
                                end
                            end
                            bcl_pkg::OP_FILTER: begin
                                if (r_count == '0) begin
                                    r_state <= ST_DECIDE;
                                end else begin
                                    r_state <= ST_SWEEP;
                                end
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SWEEP: begin
                    r_row <= ROW_BITS'(r_row + 1'b1);
                    if (CNT_BITS'(r_row) == w_last_row) begin
                        r_state <= ST_DRAIN;
                        r_drain <= '0;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= (CB + 1)'(r_drain + 1'b1);
                    if (r_drain == (CB + 1)'(NC)) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_state    <= ST_IDLE;
                    r_valid    <= 1'b1;
                    r_cnt_out  <= r_count;
                    r_full_out <= r_flag;
                    if (r_op == bcl_pkg::OP_SCAN) begin
                        if (!w_hit_final) begin
                            if (w_we) begin
                                r_count   <= n_count;
                                r_cnt_out <= n_count;
                            end else begin
                                r_flag     <= 1'b1;
                                r_full_out <= 1'b1;
                            end
                        end
                    end else if (w_hit_final) begin
                        r_removed <= 1'b1;
                    end else begin
                        r_label_out <= r_label;
                        r_seed_out  <= r_seeds_en ? r_seed : '0;
                    end
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_label_out    = r_label_out;
    assign o_seed_out     = r_seed_out;
    assign o_removed      = r_removed;
    assign o_labels_found = r_cnt_out;
    assign o_set_full     = r_full_out;

    // every request gives a result next cycle or starts a search
    `BCL_ASSERT_RST(a_accept_progress, i_clk, i_rst_n, w_accept |=> (o_valid || busy), "request neither answered nor searched")
    // a decision always yields a result and frees the block
    `BCL_ASSERT_RST(a_decide_result, i_clk, i_rst_n, (r_state == ST_DECIDE) |=> (o_valid && !busy), "decision without result")
    // a removed voxel passes neither label nor seed
    `BCL_ASSERT_RST(a_removed_zero, i_clk, i_rst_n, (o_valid && o_removed) |-> ((o_label_out == '0) && (o_seed_out == '0)), "removed voxel leaked data")
    // fill count never passes the set depth
    `BCL_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_BITS'(SET_DEPTH), "fill count beyond set depth")
    // reset empties the set
    `BCL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> ((r_count == '0) && !r_flag), "set not empty after reset")

endmodule
